// ----- hdl/straight_leg_supervisor_unit_assert.svh -----
// Assertion macros for the straight leg supervisor.
// Used by straight_leg_supervisor_unit; expects clk and arst_n in scope.
`ifndef STRAIGHT_LEG_SUPERVISOR_UNIT_ASSERT_SVH
`define STRAIGHT_LEG_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SLSUP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SLSUP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/slsup_pkg.sv -----
// Shared types and constants of the straight leg supervisor.
// No dependencies; imported by every module of the block.
package slsup_pkg;

	// Widths of the fixed fields.
	localparam int COUNT_W      = 32;
	localparam int COUNT_FIELDS = 4;
	localparam int MAG_W        = 32;
	localparam int TRAVEL_W     = 31;
	localparam int TIME_W       = 32;
	localparam int IN_TDATA_W   = 168;
	localparam int OUT_TDATA_W  = 72;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 24;

	// Largest travel value before saturation.
	localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = '1;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_FWD  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_REV  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KICK_MS     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FS_TIME_MS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_FS_MIN_TRAV = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLIP_TRAVEL = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLIP_Q8     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_HARD_MS     = 3'd7;

	// Item kinds on the input tuser.
	localparam logic MODE_START  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Leg status codes.
	typedef enum logic [2:0] {
		ST_RUNNING    = 3'd0,
		ST_REACHED    = 3'd1,
		ST_NOT_MOVING = 3'd2,
		ST_SLIP       = 3'd3,
		ST_TIMEOUT    = 3'd4,
		ST_IDLE       = 3'd5
	} status_t;

	// Wheel magnitude as carried between lanes and the merge stage.
	typedef logic [MAG_W-1:0] mag_t;

endpackage

// ----- hdl/slsup_lane.sv -----
// One wheel lane: holds the wheel's start count and forms the travel magnitude.
// Depends on slsup_pkg.
module slsup_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 is_start,
	input  logic signed [slsup_pkg::COUNT_W-1:0] count,
	output slsup_pkg::mag_t                      mag_s2
);
	import slsup_pkg::*;

	logic signed [COUNT_W-1:0] start_q;
	logic signed [COUNT_W:0]   diff;
	logic        [COUNT_W:0]   neg;

	// Exact difference against the latched start count, then its magnitude.
	always_comb begin
		diff = {count[COUNT_W-1], count} - {start_q[COUNT_W-1], start_q};
		neg  = -diff;
	end

	// A start word latches the count; a sample sees the count of the last start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (en && is_start) begin
			start_q <= count;
		end
	end

	// The magnitude always fits in the lower bits.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= diff[COUNT_W] ? neg[MAG_W-1:0] : diff[MAG_W-1:0];
		end
	end

endmodule

// ----- hdl/slsup_merge.sv -----
// Merge stage: combines the lane magnitudes into sum, minimum and maximum.
// Depends on slsup_pkg.
module slsup_merge #(
	parameter int WHEELS = 4
) (
	input  logic                                           clk,
	input  logic                                           en,
	input  slsup_pkg::mag_t                                mag [WHEELS],
	output logic [slsup_pkg::MAG_W+$clog2(WHEELS)-1:0]     sum_s3,
	output slsup_pkg::mag_t                                lo_s3,
	output slsup_pkg::mag_t                                hi_s3
);
	import slsup_pkg::*;

	localparam int SUM_W = MAG_W + $clog2(WHEELS);

	logic [SUM_W-1:0] sum;
	mag_t             lo;
	mag_t             hi;

	// Reduce across the lanes.
	always_comb begin
		sum = '0;
		lo  = mag[0];
		hi  = mag[0];
		for (int i = 0; i < WHEELS; i++) begin
			sum = sum + SUM_W'(mag[i]);
			if (mag[i] < lo) begin
				lo = mag[i];
			end
			if (mag[i] > hi) begin
				hi = mag[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum;
			lo_s3  <= lo;
			hi_s3  <= hi;
		end
	end

endmodule

// ----- hdl/slsup_divc.sv -----
// Mean travel: divides the wheel sum by the wheel count one hex digit at a
// time through a quotient table, then saturates. Depends on slsup_pkg.
module slsup_divc #(
	parameter int WHEELS = 4
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [slsup_pkg::MAG_W+$clog2(WHEELS)-1:0] sum,
	output logic [slsup_pkg::TRAVEL_W-1:0]             travel_s4
);
	import slsup_pkg::*;

	localparam int SUM_W = MAG_W + $clog2(WHEELS);
	localparam int NDIG  = (SUM_W + 3) / 4;
	localparam int PAD_W = NDIG * 4;

	// Entry for {remainder, digit}: {digit quotient, new remainder}.
	typedef logic [6:0] div_tab_t [128];

	function automatic div_tab_t build_div_tab();
		div_tab_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = {4'(i / WHEELS), 3'(i % WHEELS)};
		end
		return t;
	endfunction

	localparam div_tab_t DIV_TAB = build_div_tab();

	logic [PAD_W-1:0] padded;
	logic [PAD_W-1:0] quot;
	logic [2:0]       rem;
	logic [6:0]       ent;

	// Long division, most significant digit first.
	always_comb begin
		padded = PAD_W'(sum);
		quot   = '0;
		rem    = '0;
		ent    = '0;
		for (int d = NDIG - 1; d >= 0; d--) begin
			ent            = DIV_TAB[{rem, padded[d*4 +: 4]}];
			quot[d*4 +: 4] = ent[6:3];
			rem            = ent[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			travel_s4 <= (quot > PAD_W'(TRAVEL_MAX)) ? TRAVEL_MAX : quot[TRAVEL_W-1:0];
		end
	end

endmodule

// ----- hdl/straight_leg_supervisor_unit.sv -----
// Top level of the straight leg supervisor: input stage, wheel lanes, merge,
// divider, slip test and leg decision. Depends on slsup_pkg, slsup_lane,
// slsup_merge, slsup_divc and straight_leg_supervisor_unit_assert.svh.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tuser mode, s_tdata forward..now_ms
//  m_*      out        m_tvalid/m_tready  m_tdata status..leg_forward
//  cfg_*    in         cfg_we             cfg_index, cfg_wdata
//
// One word is accepted per cycle while the input stage can move on; a result
// passes through the five register stages (input, lanes, merge, divider
// and slip multiply, leg decision with output register) before it leaves.
// The asynchronous reset clears the pipeline valid bits, the leg state and
// the registers to their defaults. A stalled output holds its word; stages
// behind it keep filling until every stage is occupied.
module straight_leg_supervisor_unit #(
	parameter int WHEELS = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input stream.
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// forward[0], count_one[32:1], count_two[64:33], count_three[96:65],
	// count_four[128:97], now_ms[160:129], zero fill above.
	input  logic [slsup_pkg::IN_TDATA_W-1:0]       s_tdata,
	// mode[0].
	input  logic                                   s_tuser,
	// Result stream.
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// status[2:0], kick_phase[3], travel_counts[34:4], elapsed_ms[66:35],
	// leg_forward[67], zero fill above.
	output logic [slsup_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// Configuration write port.
	input  logic                                   cfg_we,
	input  logic [slsup_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [slsup_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import slsup_pkg::*;

	localparam int SUM_W = MAG_W + $clog2(WHEELS);

	// Configuration registers.
	logic [23:0] target_fwd_q;
	logic [23:0] target_rev_q;
	logic [11:0] kick_ms_q;
	logic [15:0] fs_time_q;
	logic [15:0] fs_min_q;
	logic [23:0] slip_travel_q;
	logic [9:0]  slip_q8_q;
	logic [19:0] hard_ms_q;

	// Leg state.
	logic [TIME_W-1:0] start_time_q;
	logic              dir_q;
	logic              leg_active_q;
	status_t           held_status_q;

	// Pipeline stages.
	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic                      mode_s1, mode_s2, mode_s3, mode_s4;
	logic                      fwd_s1, dir_s2, dir_s3, dir_s4;
	logic signed [COUNT_W-1:0] count_s1 [COUNT_FIELDS];
	logic [TIME_W-1:0]         now_s1, el_s2, el_s3, el_s4;
	mag_t                      mag_s2 [WHEELS];
	logic [SUM_W-1:0]          sum_s3;
	mag_t                      lo_s3, hi_s3;
	logic [TRAVEL_W-1:0]       travel_s4;
	logic                      slip_s4;

	// Output register.
	logic                      m_valid_q;
	status_t                   status_q;
	logic                      kick_q;
	logic [TRAVEL_W-1:0]       travel_q;
	logic [TIME_W-1:0]         el_q;
	logic                      dir_out_q;

	// Flow control.
	logic out_free, free4, free3, free2, free1;
	logic take1, take2, take3, take4;

	assign out_free = !m_valid_q || m_tready;
	assign free4    = !valid_s4 || out_free;
	assign free3    = !valid_s3 || free4;
	assign free2    = !valid_s2 || free3;
	assign free1    = !valid_s1 || free2;
	assign s_tready = free1;
	assign take1    = s_tvalid && free1;
	assign take2    = valid_s1 && free2;
	assign take3    = valid_s2 && free3;
	assign take4    = valid_s3 && free4;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_fwd_q  <= 24'd10570;
			target_rev_q  <= 24'd10392;
			kick_ms_q     <= 12'd220;
			fs_time_q     <= 16'd5000;
			fs_min_q      <= 16'd200;
			slip_travel_q <= 24'd7000;
			slip_q8_q     <= 10'd141;
			hard_ms_q     <= 20'd30000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_FWD:  target_fwd_q  <= cfg_wdata;
				CFG_TARGET_REV:  target_rev_q  <= cfg_wdata;
				CFG_KICK_MS:     kick_ms_q     <= cfg_wdata[11:0];
				CFG_FS_TIME_MS:  fs_time_q     <= cfg_wdata[15:0];
				CFG_FS_MIN_TRAV: fs_min_q      <= cfg_wdata[15:0];
				CFG_SLIP_TRAVEL: slip_travel_q <= cfg_wdata;
				CFG_SLIP_Q8:     slip_q8_q     <= cfg_wdata[9:0];
				CFG_HARD_MS:     hard_ms_q     <= cfg_wdata[19:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (free1) valid_s1 <= s_tvalid;
			if (free2) valid_s2 <= valid_s1;
			if (free3) valid_s3 <= valid_s2;
			if (free4) valid_s4 <= valid_s3;
		end
	end

	// Input stage: unpack the word.
	always_ff @(posedge clk) begin
		if (take1) begin
			mode_s1 <= s_tuser;
			fwd_s1  <= s_tdata[0];
			now_s1  <= s_tdata[129 +: TIME_W];
			for (int i = 0; i < COUNT_FIELDS; i++) begin
				count_s1[i] <= s_tdata[1 + COUNT_W*i +: COUNT_W];
			end
		end
	end

	// Wheel lanes; wheels beyond the input fields read a count of zero.
	for (genvar g = 0; g < WHEELS; g++) begin : g_lane
		logic signed [COUNT_W-1:0] lane_count;
		if (g < COUNT_FIELDS) begin : g_field
			assign lane_count = count_s1[g];
		end else begin : g_zero
			assign lane_count = '0;
		end
		slsup_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (take2),
			.is_start (mode_s1 == MODE_START),
			.count    (lane_count),
			.mag_s2   (mag_s2[g])
		);
	end

	// Start time and direction latch as a start word enters the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			dir_q        <= 1'b1;
		end else if (take2 && mode_s1 == MODE_START) begin
			start_time_q <= now_s1;
			dir_q        <= fwd_s1;
		end
	end

	// Side band of the lane stage.
	always_ff @(posedge clk) begin
		if (take2) begin
			mode_s2 <= mode_s1;
			dir_s2  <= (mode_s1 == MODE_START) ? fwd_s1 : dir_q;
			el_s2   <= now_s1 - start_time_q;
		end
	end

	slsup_merge #(.WHEELS(WHEELS)) u_merge (
		.clk    (clk),
		.en     (take3),
		.mag    (mag_s2),
		.sum_s3 (sum_s3),
		.lo_s3  (lo_s3),
		.hi_s3  (hi_s3)
	);

	always_ff @(posedge clk) begin
		if (take3) begin
			mode_s3 <= mode_s2;
			dir_s3  <= dir_s2;
			el_s3   <= el_s2;
		end
	end

	slsup_divc #(.WHEELS(WHEELS)) u_divc (
		.clk       (clk),
		.en        (take4),
		.sum       (sum_s3),
		.travel_s4 (travel_s4)
	);

	// Slip test: (hi - lo) * 256 > limit * lo, a zero minimum counts as 1.0.
	logic [MAG_W-1:0]  spread;
	logic [MAG_W+9:0]  limit_prod;
	logic              slip_hit;

	always_comb begin
		spread     = hi_s3 - lo_s3;
		limit_prod = slip_q8_q * lo_s3;
		if (lo_s3 == '0) begin
			slip_hit = (slip_q8_q < 10'd256);
		end else begin
			slip_hit = ({2'b00, spread, 8'h00} > limit_prod);
		end
	end

	always_ff @(posedge clk) begin
		if (take4) begin
			mode_s4 <= mode_s3;
			dir_s4  <= dir_s3;
			el_s4   <= el_s3;
			slip_s4 <= slip_hit;
		end
	end

	// Leg decision.
	logic                do_out;
	status_t             status_d;
	logic                kick_d;
	logic [TRAVEL_W-1:0] travel_d;
	logic [TIME_W-1:0]   el_d;
	logic [23:0]         target;
	logic                leg_end;

	assign do_out = valid_s4 && out_free;
	assign target = dir_s4 ? target_fwd_q : target_rev_q;

	always_comb begin
		status_d = held_status_q;
		kick_d   = 1'b0;
		travel_d = travel_s4;
		el_d     = el_s4;
		leg_end  = 1'b0;
		if (mode_s4 == MODE_START) begin
			status_d = ST_RUNNING;
			kick_d   = (kick_ms_q != '0);
			travel_d = '0;
			el_d     = '0;
		end else if (leg_active_q) begin
			if (el_s4 < TIME_W'(kick_ms_q)) begin
				status_d = ST_RUNNING;
				kick_d   = 1'b1;
			end else begin
				priority if (travel_s4 >= TRAVEL_W'(target)) begin
					status_d = ST_REACHED;
				end else if (el_s4 > TIME_W'(fs_time_q) && travel_s4 < TRAVEL_W'(fs_min_q)) begin
					status_d = ST_NOT_MOVING;
				end else if (travel_s4 > TRAVEL_W'(slip_travel_q) && slip_s4) begin
					status_d = ST_SLIP;
				end else if (el_s4 > TIME_W'(hard_ms_q)) begin
					status_d = ST_TIMEOUT;
				end else begin
					status_d = ST_RUNNING;
				end
				leg_end = (status_d != ST_RUNNING);
			end
		end
	end

	// Leg state follows each word as it leaves the decision stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leg_active_q  <= 1'b0;
			held_status_q <= ST_IDLE;
		end else if (do_out) begin
			if (mode_s4 == MODE_START) begin
				leg_active_q  <= 1'b1;
				held_status_q <= ST_RUNNING;
			end else if (leg_end) begin
				leg_active_q  <= 1'b0;
				held_status_q <= status_d;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (do_out) begin
			status_q  <= status_d;
			kick_q    <= kick_d;
			travel_q  <= travel_d;
			el_q      <= el_d;
			dir_out_q <= dir_s4;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'h0, dir_out_q, el_q, travel_q, kick_q, status_q};

	// Checks on the block's own logic.
	`include "straight_leg_supervisor_unit_assert.svh"

	`SLSUP_ASSERT_NOW(a_kick_running, m_valid_q && kick_q, status_q == ST_RUNNING, "kick phase outside running status")
	`SLSUP_ASSERT_NOW(a_idle_held, !leg_active_q, held_status_q != ST_RUNNING, "ended leg holds running status")
	`SLSUP_ASSERT_NOW(a_full_stall, !s_tready, valid_s1 && valid_s2 && valid_s3 && valid_s4 && m_valid_q && !m_tready, "input stalled with a free stage")
	`SLSUP_ASSERT_NEXT(a_start_opens, do_out && mode_s4 == MODE_START, leg_active_q, "start word did not open a leg")

endmodule

// ----- test/tb.sv -----
// Self-checking bench for straight_leg_supervisor_unit: directed table, then random legs.
// Depends on slsup_pkg and the block's RTL; checks every result word against a local predictor.
`timescale 1ns / 100ps

module tb;
	import slsup_pkg::*;

	typedef logic [0:3][31:0] wheel_cnt_t;

	// One result word, field by field.
	typedef struct packed {
		status_t     status;
		logic        kick;
		logic [30:0] travel;
		logic [31:0] elapsed;
		logic        fwd;
	} leg_res_t;

	// One row of the directed table; want is only used when typed is set.
	typedef struct packed {
		logic        mode;
		logic        fwd;
		wheel_cnt_t  cnt;
		logic [31:0] now;
		logic        typed;
		leg_res_t    want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Side data that travels with a directed word whose result is typed in.
	bit typed_flag = 1'b0;
	leg_res_t typed_want = '0;

	int snd_idle_pct = 38;
	int rcv_idle_pct = 56;
	int n_bad = 0;
	int n_sent = 0;

	// Predictor state: register copy and leg state.
	logic [CFG_DATA_W-1:0] cfg_reg [8] = '{24'd10570, 24'd10392, 24'd220, 24'd5000,
		24'd200, 24'd7000, 24'd141, 24'd30000};
	logic [31:0] origin_cnt [4] = '{32'd0, 32'd0, 32'd0, 32'd0};
	logic [31:0] origin_ms = '0;
	logic leg_fwd = 1'b1;
	logic leg_live = 1'b0;
	status_t leg_held = ST_IDLE;

	leg_res_t leg_want_q [$];

	// Directed table: reset state, count and time extremes, every check and its order.
	dir_row_t dir_rows [23] = '{
		'{MODE_SAMPLE, 1'b0, '{32'd0, 32'd0, 32'd0, 32'd0}, 32'd1234, 1'b1,
			'{ST_IDLE, 1'b0, 31'd0, 32'd1234, 1'b1}},
		'{MODE_SAMPLE, 1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			32'hFFFF_FFFF, 1'b1, '{ST_IDLE, 1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
		'{MODE_SAMPLE, 1'b0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			32'd0, 1'b1, '{ST_IDLE, 1'b0, 31'h7FFF_FFFF, 32'd0, 1'b1}},
		'{MODE_SAMPLE, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			32'd0, 1'b1, '{ST_IDLE, 1'b0, 31'd1, 32'd0, 1'b1}},
		'{MODE_START, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}, 32'd100, 1'b1,
			'{ST_RUNNING, 1'b1, 31'd0, 32'd0, 1'b1}},
		'{MODE_SAMPLE, 1'b0, '{32'd50, 32'd50, 32'd50, 32'd50}, 32'd319, 1'b0, '0},
		'{MODE_SAMPLE, 1'b0, '{32'd100, 32'd100, 32'd100, 32'd100}, 32'd320, 1'b0, '0},
		'{MODE_SAMPLE, 1'b1, '{32'd10570, 32'd10570, 32'd10570, 32'd10570}, 32'd400, 1'b0, '0},
		'{MODE_SAMPLE, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}, 32'd500, 1'b0, '0},
		'{MODE_START, 1'b0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			32'hFFFF_FF00, 1'b1, '{ST_RUNNING, 1'b1, 31'd0, 32'd0, 1'b0}},
		'{MODE_SAMPLE, 1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			32'h0000_0100, 1'b0, '0},
		'{MODE_START, 1'b1, '{-32'sd1000, -32'sd1000, -32'sd1000, -32'sd1000}, 32'd0, 1'b1,
			'{ST_RUNNING, 1'b1, 31'd0, 32'd0, 1'b1}},
		'{MODE_SAMPLE, 1'b0, '{-32'sd990, -32'sd990, -32'sd990, -32'sd990}, 32'd5001, 1'b0, '0},
		'{MODE_START, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}, 32'd0, 1'b0, '0},
		'{MODE_SAMPLE, 1'b1, '{32'd8000, 32'd8000, 32'd8000, 32'd4000}, 32'd300, 1'b0, '0},
		'{MODE_SAMPLE, 1'b1, '{32'd9000, 32'd9000, 32'd9000, 32'd4000}, 32'd400, 1'b0, '0},
		'{MODE_START, 1'b0, '{32'd0, 32'd0, 32'd0, 32'd0}, 32'd1000, 1'b0, '0},
		'{MODE_SAMPLE, 1'b0, '{-32'sd10000, -32'sd10000, -32'sd10000, 32'd0}, 32'd1300,
			1'b0, '0},
		'{MODE_START, 1'b1, '{32'd5, 32'd5, 32'd5, 32'd5}, 32'd7, 1'b0, '0},
		'{MODE_SAMPLE, 1'b1, '{32'd305, 32'd305, 32'd305, 32'd305}, 32'd30008, 1'b0, '0},
		'{MODE_SAMPLE, 1'b0, '{32'd5, 32'd605, -32'sd595, 32'd5}, 32'd30010, 1'b0, '0},
		'{MODE_START, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}, 32'd0, 1'b0, '0},
		'{MODE_SAMPLE, 1'b1, '{32'd300, 32'd300, 32'd300, 32'd300}, 32'd30000, 1'b0, '0}
	};

	straight_leg_supervisor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Works out the result of one accepted word and advances the leg state.
	function automatic leg_res_t predict_leg(input logic mode, input logic fwd,
			input wheel_cnt_t cnt, input logic [31:0] now);
		leg_res_t r;
		longint d;
		logic [63:0] mag, sum, lo, hi, got, tgt;
		logic [31:0] el;
		logic slip;
		status_t st;
		r = '0;
		if (mode == MODE_START) begin
			for (int i = 0; i < 4; i++) origin_cnt[i] = cnt[i];
			origin_ms = now;
			leg_fwd = fwd;
			leg_live = 1'b1;
			leg_held = ST_RUNNING;
			r.status = ST_RUNNING;
			r.kick = (cfg_reg[CFG_KICK_MS] != 0);
			r.fwd = fwd;
			return r;
		end
		// Mean of the absolute wheel changes, with the smallest and largest one.
		sum = '0;
		lo = '0;
		hi = '0;
		for (int i = 0; i < 4; i++) begin
			d = longint'($signed(cnt[i])) - longint'($signed(origin_cnt[i]));
			mag = (d < 0) ? -d : d;
			sum += mag;
			if (i == 0 || mag < lo) lo = mag;
			if (mag > hi) hi = mag;
		end
		got = sum >> 2;
		if (got > 64'h7FFF_FFFF) got = 64'h7FFF_FFFF;
		el = now - origin_ms;
		r.status = leg_held;
		r.travel = got[30:0];
		r.elapsed = el;
		r.fwd = leg_fwd;
		if (leg_live) begin
			tgt = leg_fwd ? cfg_reg[CFG_TARGET_FWD] : cfg_reg[CFG_TARGET_REV];
			// A zero minimum counts as a spread ratio of exactly one.
			slip = (lo == 0) ? (cfg_reg[CFG_SLIP_Q8] < 256)
				: ((hi - lo) * 256 > cfg_reg[CFG_SLIP_Q8] * lo);
			if (el < cfg_reg[CFG_KICK_MS]) begin
				r.status = ST_RUNNING;
				r.kick = 1'b1;
			end else begin
				if (got >= tgt)
					st = ST_REACHED;
				else if (el > cfg_reg[CFG_FS_TIME_MS] && got < cfg_reg[CFG_FS_MIN_TRAV])
					st = ST_NOT_MOVING;
				else if (got > cfg_reg[CFG_SLIP_TRAVEL] && slip)
					st = ST_SLIP;
				else if (el > cfg_reg[CFG_HARD_MS])
					st = ST_TIMEOUT;
				else
					st = ST_RUNNING;
				r.status = st;
				if (st != ST_RUNNING) begin
					leg_live = 1'b0;
					leg_held = st;
				end
			end
		end
		return r;
	endfunction

	task automatic report_bad(input string msg);
		$display("%0t ns: %s", $time, msg);
		n_bad++;
	endtask

	task automatic check_field(input string name, input logic [63:0] seen,
			input logic [63:0] want);
		if (seen !== want)
			report_bad($sformatf("%s is %0h, predicted %0h", name, seen, want));
	endtask

	// Tracks register writes and accepted words, and checks each result word.
	always @(posedge clk) begin
		leg_res_t seen, want;
		wheel_cnt_t c;
		if (arst_n) begin
			if (cfg_we) cfg_reg[cfg_index] = cfg_wdata;
			if (s_tvalid && s_tready) begin
				for (int i = 0; i < 4; i++) c[i] = s_tdata[1 + 32 * i +: 32];
				want = predict_leg(s_tuser, s_tdata[0], c, s_tdata[160:129]);
				if (typed_flag) want = typed_want;
				leg_want_q.push_back(want);
			end
			if (m_tvalid === 1'b1 && m_tready) begin
				seen.status = status_t'(m_tdata[2:0]);
				seen.kick = m_tdata[3];
				seen.travel = m_tdata[34:4];
				seen.elapsed = m_tdata[66:35];
				seen.fwd = m_tdata[67];
				if (leg_want_q.size() == 0) begin
					report_bad("result word arrived with none pending");
				end else begin
					want = leg_want_q.pop_front();
					check_field("status", seen.status, want.status);
					check_field("kick_phase", seen.kick, want.kick);
					check_field("travel_counts", seen.travel, want.travel);
					check_field("elapsed_ms", seen.elapsed, want.elapsed);
					check_field("leg_forward", seen.fwd, want.fwd);
				end
			end
		end
	end

	// Offers one word after a random gap and returns at the edge that takes it.
	task automatic send_word(input logic mode, input logic fwd, input wheel_cnt_t cnt,
			input logic [31:0] now, input bit typed, input leg_res_t want);
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'd0, now, cnt[3], cnt[2], cnt[1], cnt[0], fwd};
		typed_flag <= typed;
		typed_want <= want;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		n_sent++;
	endtask

	// Holds the input off until every pending result word has come back.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (leg_want_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] setv [8];
		int quota [6];
		int goal_items, midpoint, n, kind;
		int pct [4];
		int sgn [4];
		logic fwd;
		logic [31:0] base [4];
		logic [31:0] t0, span, el;
		longint goal, trav;
		wheel_cnt_t cnt;
		quota = '{400, 300, 400, 150, 400, 300};
		goal_items = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset register values.
		foreach (dir_rows[i])
			send_word(dir_rows[i].mode, dir_rows[i].fwd, dir_rows[i].cnt, dir_rows[i].now,
				dir_rows[i].typed, dir_rows[i].want);
		settle();

		for (int p = 0; p < 6; p++) begin
			// Register setting of this phase: random, all highest, all zero, reset values.
			case (p)
				1: begin
					setv[CFG_TARGET_FWD] = 24'hFF_FFFF;
					setv[CFG_TARGET_REV] = 24'hFF_FFFF;
					setv[CFG_KICK_MS] = 24'd4095;
					setv[CFG_FS_TIME_MS] = 24'd65535;
					setv[CFG_FS_MIN_TRAV] = 24'd65535;
					setv[CFG_SLIP_TRAVEL] = 24'hFF_FFFF;
					setv[CFG_SLIP_Q8] = 24'd1023;
					setv[CFG_HARD_MS] = 24'd1048575;
				end
				3: begin
					foreach (setv[i]) setv[i] = '0;
				end
				5: begin
					setv[CFG_TARGET_FWD] = 24'd10570;
					setv[CFG_TARGET_REV] = 24'd10392;
					setv[CFG_KICK_MS] = 24'd220;
					setv[CFG_FS_TIME_MS] = 24'd5000;
					setv[CFG_FS_MIN_TRAV] = 24'd200;
					setv[CFG_SLIP_TRAVEL] = 24'd7000;
					setv[CFG_SLIP_Q8] = 24'd141;
					setv[CFG_HARD_MS] = 24'd30000;
				end
				default: begin
					setv[CFG_TARGET_FWD] = $urandom_range(20000, 50);
					setv[CFG_TARGET_REV] = $urandom_range(20000, 50);
					setv[CFG_KICK_MS] = $urandom_range(600);
					setv[CFG_FS_TIME_MS] = $urandom_range(8000);
					setv[CFG_FS_MIN_TRAV] = $urandom_range(600);
					setv[CFG_SLIP_TRAVEL] = $urandom_range(20000);
					setv[CFG_SLIP_Q8] = $urandom_range(1023);
					setv[CFG_HARD_MS] = $urandom_range(60000);
				end
			endcase
			for (int i = 0; i < 8; i++) begin
				@(negedge clk);
				cfg_we <= 1'b1;
				cfg_index <= i[CFG_INDEX_W-1:0];
				cfg_wdata <= setv[i];
				@(negedge clk);
				cfg_we <= 1'b0;
			end

			// Receiver-heavy idling first, then sender-heavy, then none.
			snd_idle_pct = (p < 2) ? 38 : (p < 4) ? 56 : 0;
			rcv_idle_pct = (p < 2) ? 56 : (p < 4) ? 38 : 0;
			midpoint = n_sent + quota[p] / 2;
			goal_items += quota[p];
			while (n_sent < 23 + goal_items) begin
				// Occasional noise: fully random words, starts in the middle of a leg.
				if ($urandom_range(7) == 0) begin
					repeat ($urandom_range(3, 1)) begin
						for (int i = 0; i < 4; i++) cnt[i] = $urandom();
						send_word($urandom_range(1), $urandom_range(1), cnt, $urandom(), 1'b0,
							'0);
					end
				end

				// A well-formed leg: start, then samples with growing travel and time.
				fwd = $urandom_range(1);
				t0 = $urandom();
				for (int i = 0; i < 4; i++) begin
					base[i] = $urandom();
					cnt[i] = base[i];
					pct[i] = $urandom_range(108, 92);
					sgn[i] = fwd ? 1 : -1;
					if ($urandom_range(7) == 0) sgn[i] = -sgn[i];
				end
				kind = $urandom_range(5);
				goal = fwd ? cfg_reg[CFG_TARGET_FWD] : cfg_reg[CFG_TARGET_REV];
				goal = goal * $urandom_range(150, 50) / 100 + $urandom_range(2);
				// Barely moving, one wheel slipping, or one wheel stuck.
				if (kind == 0) goal = $urandom_range(cfg_reg[CFG_FS_MIN_TRAV] + 10);
				if (kind == 1) pct[$urandom_range(3)] = $urandom_range(70);
				if (kind == 2) pct[$urandom_range(3)] = 0;
				case ($urandom_range(2))
					0: span = cfg_reg[CFG_HARD_MS] + $urandom_range(cfg_reg[CFG_HARD_MS] / 4 + 10);
					1: span = cfg_reg[CFG_FS_TIME_MS] + $urandom_range(100);
					default: span = $urandom_range(cfg_reg[CFG_KICK_MS] * 2 + 10);
				endcase
				n = $urandom_range(12, 3);
				send_word(MODE_START, fwd, cnt, t0, 1'b0, '0);
				for (int k = 1; k <= n; k++) begin
					el = span * k / n;
					for (int i = 0; i < 4; i++) begin
						trav = goal * k * pct[i] / (n * 100);
						cnt[i] = base[i] + sgn[i] * trav;
					end
					if ($urandom_range(19) == 0) cnt[$urandom_range(3)] = $urandom();
					send_word(MODE_SAMPLE, $urandom_range(1), cnt, t0 + el, 1'b0, '0);
				end

				// Once per phase the input waits for the output side to run dry.
				if (midpoint != 0 && n_sent >= midpoint) begin
					settle();
					midpoint = 0;
				end
			end
			settle();
		end

		if (n_bad == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/slsup_pkg.sv
hdl/slsup_lane.sv
hdl/slsup_merge.sv
hdl/slsup_divc.sv
hdl/straight_leg_supervisor_unit.sv
test/tb.sv
